// ===== rtl/ccv_pkg.sv =====
package ccv_pkg;

   localparam int SMP_W   = 16;
   localparam int IDX_W   = 10;
   localparam int POS_W   = 10;
   localparam int PROD_W  = 2 * SMP_W;
   localparam int ACC_W   = 48;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 64;

   // req_tdata field offsets
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_TAP_LSB   = REQ_IDX_LSB + IDX_W;
   localparam int REQ_SMP_LSB   = REQ_TAP_LSB + SMP_W;
   localparam int REQ_FIRST_BIT = REQ_SMP_LSB + SMP_W;

   // req_tuser codes
   localparam logic CMD_TAP    = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Saturating accumulate: one extra bit catches any single-step overflow.
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0]  acc,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [ACC_W:0] sum;
      sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sat_add = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_add = sum[ACC_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/ccv_ram.sv =====
module ccv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/causal_convolution_engine.sv =====
// Direct-form FIR over a restartable sample series. A beat with req_tuser low writes one
// tap (taps start at zero); a beat with req_tuser high appends a sample at position i and
// returns y[i] = sum of tap[t]*x[i-t] for t = 0..i, saturated to 48 bits (Q18.30). Taps and
// history sit in two single-port-read RAMs; one multiply-accumulate is issued per cycle, so
// a sample at position i makes i+1 reads and then passes the RAM, product and handoff
// stages; a tap write leaves the block ready for the next beat. Samples past MAX_LEN in a
// series are dropped and answered with the overflow flag set. After reset the tap RAM is
// swept to zero, and req_tready is low while the sweep runs. The result register lets a new
// beat be taken while the previous result still waits on rsp_tready.
module causal_convolution_engine #(
   parameter int MAX_LEN = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] tap_index, [25:10] tap_value, [41:26] sample_value, [42] first_sample
   input  logic [ccv_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] cmd
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [47:0] filtered_value, [57:48] sample_position
   output logic [ccv_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] overflow_flag
   output logic                              rsp_tuser
);

   import ccv_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] pos_cnt_ff, pos_cnt_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] t_ff, t_in;
   logic          vld1_ff, vld1_in, last1_ff, last1_in;
   logic          vld2_ff, vld2_in, last2_ff, last2_in;
   logic          ovf_ff, ovf_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0]  rsp_acc_ff, rsp_acc_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic              req_acc;
   logic [IDX_W-1:0]  req_idx;
   logic [SMP_W-1:0]  req_tap;
   logic [SMP_W-1:0]  req_smp;
   logic              req_first;
   logic [CW-1:0]     eff_cnt;
   logic              idx_ok;

   logic              tap_we, hist_we, rd_en;
   logic [AW-1:0]     tap_wa;
   logic [SMP_W-1:0]  tap_wd;
   logic [AW-1:0]     hist_ra;
   logic signed [SMP_W-1:0] tap_q, hist_q;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_idx    = req_tdata[REQ_IDX_LSB +: IDX_W];
   assign req_tap    = req_tdata[REQ_TAP_LSB +: SMP_W];
   assign req_smp    = req_tdata[REQ_SMP_LSB +: SMP_W];
   assign req_first  = req_tdata[REQ_FIRST_BIT];
   assign eff_cnt    = req_first ? '0 : pos_cnt_ff;
   assign idx_ok     = 32'(req_idx) < MAX_LEN;
   assign hist_ra    = pos_ff - t_ff;

   ccv_ram #(.WIDTH(SMP_W), .DEPTH(MAX_LEN)) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_we),
      .wr_addr (tap_wa),
      .wr_data (tap_wd),
      .rd_en   (rd_en),
      .rd_addr (t_ff),
      .rd_data (tap_q)
   );

   // sample write happens on the accept beat, reads of it start the cycle after
   ccv_ram #(.WIDTH(SMP_W), .DEPTH(MAX_LEN)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (AW'(eff_cnt)),
      .wr_data (req_smp),
      .rd_en   (rd_en),
      .rd_addr (hist_ra),
      .rd_data (hist_q)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_cnt_in   = pos_cnt_ff;
      pos_in       = pos_ff;
      t_in         = t_ff;
      ovf_in       = ovf_ff;
      vld1_in      = 1'b0;
      last1_in     = 1'b0;
      vld2_in      = vld1_ff;
      last2_in     = last1_ff;
      prod_in      = tap_q * hist_q;
      acc_in       = vld2_ff ? sat_add(acc_ff, prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      tap_we       = 1'b0;
      tap_wa       = clr_ff;
      tap_wd       = '0;
      hist_we      = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            tap_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == CMD_TAP) begin
                  tap_we = idx_ok;
                  tap_wa = AW'(req_idx);
                  tap_wd = req_tap;
               end else if (eff_cnt == CW'(MAX_LEN)) begin
                  pos_cnt_in = eff_cnt;
                  pos_in     = '0;
                  ovf_in     = 1'b1;
                  acc_in     = '0;
                  state_in   = ST_DONE;
               end else begin
                  hist_we    = 1'b1;
                  pos_cnt_in = eff_cnt + 1'b1;
                  pos_in     = AW'(eff_cnt);
                  t_in       = '0;
                  ovf_in     = 1'b0;
                  acc_in     = '0;
                  state_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            rd_en   = 1'b1;
            vld1_in = 1'b1;
            t_in    = t_ff + 1'b1;
            if (t_ff == pos_ff) begin
               last1_in = 1'b1;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // final product is added on this same edge
            if (last2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_pos_in   = POS_W'(pos_ff);
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pos_in_hold: begin
         pos_ff     <= pos_in;
         t_ff       <= t_in;
         ovf_ff     <= ovf_in;
         prod_ff    <= prod_in;
         acc_ff     <= acc_in;
         rsp_acc_ff <= rsp_acc_in;
         rsp_pos_ff <= rsp_pos_in;
         rsp_ovf_ff <= rsp_ovf_in;
      end
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pos_cnt_ff   <= '0;
         vld1_ff      <= 1'b0;
         last1_ff     <= 1'b0;
         vld2_ff      <= 1'b0;
         last2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pos_cnt_ff   <= pos_cnt_in;
         vld1_ff      <= vld1_in;
         last1_ff     <= last1_in;
         vld2_ff      <= vld2_in;
         last2_ff     <= last2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - ACC_W - POS_W){1'b0}}, rsp_pos_ff, rsp_acc_ff};
   assign rsp_tuser  = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the done state");

   a_last_in_drain: assert property (@(posedge clock) disable iff (reset)
      (last1_ff || last2_ff) |-> state_ff == ST_DRAIN)
      else $error("last product seen outside drain");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tdata == '0)
      else $error("dropped sample carries nonzero data");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pos_cnt_ff) <= MAX_LEN)
      else $error("position count past store depth");

   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> t_ff <= pos_ff)
      else $error("tap counter ran past sample position");
`endif

endmodule

// ===== test/tb_causal_convolution_engine.sv =====
module tb_causal_convolution_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import ccv_pkg::*;

   localparam int     DEPTH       = 1024;
   localparam int     HOLD_CYCLES = 400;
   localparam int     CYCLE_LIMIT = 3_000_000;
   localparam int     RSP_POS_LSB = ACC_W;
   localparam longint FILT_MAX    = (longint'(1) << (ACC_W - 1)) - 1;
   localparam longint FILT_MIN    = -FILT_MAX - 1;

   typedef struct {
      logic                    cmd;
      logic [IDX_W-1:0]        tap_index;
      logic signed [SMP_W-1:0] tap_value;
      logic signed [SMP_W-1:0] sample_value;
      logic                    first_sample;
   } conv_item_type;

   typedef struct {
      logic signed [ACC_W-1:0] filtered;
      logic [POS_W-1:0]        position;
      logic                    overflow;
   } conv_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   // filter state as seen by the checker
   logic signed [SMP_W-1:0] coeff_mem   [0:DEPTH-1];
   logic signed [SMP_W-1:0] history_mem [0:DEPTH-1];
   int                      series_pos;

   conv_item_type   pending_items[$];
   conv_result_type expected_results[$];
   conv_item_type   cur_item;

   int accepted_count = 0;
   int send_idle_pct  = 17;
   int recv_idle_pct  = 74;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int hold_at        = 0;
   int run_left       = 0;

   int fail_count     = 0;
   int results_seen   = 0;
   int drops_seen     = 0;
   int samples_in     = 0;
   int taps_in        = 0;
   int deepest_pos    = 0;

   causal_convolution_engine #(.MAX_LEN(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Updates the filter state for one beat; returns 1 when the beat answers.
   function automatic bit filter_response(input conv_item_type it,
                                          output conv_result_type res);
      longint acc;
      longint prod;
      int     p;
      res = '{default: '0};
      if (it.cmd == CMD_TAP) begin
         if (int'(it.tap_index) < DEPTH) coeff_mem[it.tap_index] = it.tap_value;
         taps_in++;
         return 1'b0;
      end
      samples_in++;
      if (it.first_sample) series_pos = 0;
      if (series_pos >= DEPTH) begin
         series_pos   = DEPTH;
         res.overflow = 1'b1;
         return 1'b1;
      end
      p = series_pos;
      history_mem[p] = it.sample_value;
      acc = 0;
      for (int t = 0; t <= p; t++) begin
         prod = longint'(coeff_mem[t]) * longint'(history_mem[p - t]);
         acc += prod;
         if (acc > FILT_MAX) acc = FILT_MAX;
         else if (acc < FILT_MIN) acc = FILT_MIN;
      end
      series_pos   = p + 1;
      if (p > deepest_pos) deepest_pos = p;
      res.filtered = acc[ACC_W-1:0];
      res.position = p[POS_W-1:0];
      return 1'b1;
   endfunction

   function automatic logic signed [SMP_W-1:0] pick_word();
      int r;
      r = $urandom_range(15);
      if (r < 2) return 16'sh7FFF;
      if (r < 4) return 16'sh8000;
      if (r == 4) return '0;
      return SMP_W'($urandom);
   endfunction

   task automatic add_tap(input int idx, input logic signed [SMP_W-1:0] val);
      conv_item_type it;
      it.cmd          = CMD_TAP;
      it.tap_index    = idx[IDX_W-1:0];
      it.tap_value    = val;
      it.sample_value = SMP_W'($urandom);
      it.first_sample = 1'($urandom_range(1));
      pending_items   = {pending_items, it};
   endtask

   task automatic add_sample(input logic signed [SMP_W-1:0] val, input logic first);
      conv_item_type it;
      it.cmd          = CMD_SAMPLE;
      it.tap_index    = IDX_W'($urandom);
      it.tap_value    = SMP_W'($urandom);
      it.sample_value = val;
      it.first_sample = first;
      pending_items   = {pending_items, it};
   endtask

   // Series of random length with taps mixed in; a few mid-series restarts and
   // unflagged series starts as noise.
   task automatic add_random_items(input int count);
      int r;
      int n;
      bit starting;
      n = 0;
      while (n < count) begin
         starting = 1'b0;
         if (run_left == 0) begin
            r = $urandom_range(99);
            if (r < 85) run_left = $urandom_range(1, 24);
            else if (r < 98) run_left = $urandom_range(25, 100);
            else run_left = $urandom_range(101, 300);
            starting = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 15) begin
            add_tap(($urandom_range(9) < 7) ? $urandom_range(31) : $urandom_range(DEPTH - 1),
                    pick_word());
         end else begin
            add_sample(pick_word(), starting ? ($urandom_range(9) != 0)
                                             : ($urandom_range(49) == 0));
            run_left--;
         end
         n++;
      end
   endtask

   always @(posedge clock) begin : drive
      conv_result_type res;
      logic [REQ_TDATA_W-1:0] beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (filter_response(cur_item, res)) expected_results = {expected_results, res};
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_item = pending_items.pop_front();
               beat = '0;
               beat[REQ_IDX_LSB +: IDX_W] = cur_item.tap_index;
               beat[REQ_TAP_LSB +: SMP_W] = cur_item.tap_value;
               beat[REQ_SMP_LSB +: SMP_W] = cur_item.sample_value;
               beat[REQ_FIRST_BIT]        = cur_item.first_sample;
               req_tdata  <= beat;
               req_tuser  <= cur_item.cmd;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off at the start of the no-idle phase
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && hold_at != 0 && accepted_count >= hold_at) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      conv_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               results_seen++;
               if (rsp_tuser) drops_seen++;
               if ($signed(rsp_tdata[ACC_W-1:0]) !== want.filtered) begin
                  $error("filtered_value: expected %0d, got %0d", want.filtered,
                         $signed(rsp_tdata[ACC_W-1:0]));
                  fail_count++;
               end
               if (rsp_tdata[RSP_POS_LSB +: POS_W] !== want.position) begin
                  $error("sample_position: expected %0d, got %0d", want.position,
                         rsp_tdata[RSP_POS_LSB +: POS_W]);
                  fail_count++;
               end
               if (rsp_tuser !== want.overflow) begin
                  $error("overflow_flag: expected %0b, got %0b", want.overflow, rsp_tuser);
                  fail_count++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $error("timeout, %0d items unsent, %0d results outstanding",
             pending_items.size(), expected_results.size());
      $display("[causal_convolution_engine] ERROR");
      $finish;
   end

   initial begin
      int phase2_at;
      int phase3_at;
      for (int i = 0; i < DEPTH; i++) begin
         coeff_mem[i]   = '0;
         history_mem[i] = '0;
      end
      series_pos = 0;

      // all taps still zero
      add_sample(16'sh7FFF, 1'b1);
      add_tap(0, 16'sh7FFF);
      add_tap(1, 16'sh8000);
      add_tap(2, 16'sh0001);
      add_tap(DEPTH - 1, 16'sh8000);
      add_sample(16'sh8000, 1'b1);
      add_sample(16'sh7FFF, 1'b0);
      add_sample(16'sh8000, 1'b0);
      add_sample(16'sh0000, 1'b0);
      add_sample(-16'sh0001, 1'b0);
      // tap change mid-series only affects later samples
      add_tap(0, -16'sh0001);
      add_sample(16'sh0001, 1'b0);
      add_sample(16'sh7FFF, 1'b1);
      add_sample(16'sh7FFF, 1'b0);
      add_tap(3, 16'sh7FFF);
      add_tap(3, 16'sh0000);
      add_sample(16'sh8000, 1'b0);
      add_sample(16'sh8000, 1'b0);
      add_sample(16'sh0001, 1'b1);
      add_tap(0, 16'sh7FFF);

      add_random_items(200);
      phase2_at = pending_items.size();
      add_random_items(180);
      phase3_at = pending_items.size();
      add_random_items(180);
      hold_at = phase3_at;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (accepted_count < phase2_at);
      send_idle_pct = 74;
      recv_idle_pct = 17;
      do @(negedge clock); while (accepted_count < phase3_at);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      do @(negedge clock); while (pending_items.size() != 0 || req_tvalid);
      while (expected_results.size() != 0) @(negedge clock);
      // a trailing tap write may still be in flight
      repeat (16) @(posedge clock);

      $display("Checked %0d results (%0d dropped past the store) from %0d samples, %0d taps.",
               results_seen, drops_seen, samples_in, taps_in);
      $display("Deepest series position %0d; mixed idling and a %0d-cycle output hold-off.",
               deepest_pos, HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("[causal_convolution_engine] OK");
      end else begin
         $display("[causal_convolution_engine] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ccv_pkg.sv
rtl/ccv_ram.sv
rtl/causal_convolution_engine.sv
test/tb_causal_convolution_engine.sv
